### src/lsfs_pkg.sv
// Shared types, request codes and defaults for the LED strip frame serializer.
`timescale 1ns / 1ps
`default_nettype none

package lsfs_pkg;

  localparam int unsigned MAX_LEDS_DEF     = 256;
  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned NUM_LEDS_W       = 9;
  localparam int unsigned NUM_LEDS_RESET   = 256;
  localparam int unsigned COLOUR_W         = 15;

  typedef enum logic [1:0] {
    REQ_WR_PACKED = 2'd0,
    REQ_WR_RGB    = 2'd1,
    REQ_START     = 2'd2,
    REQ_TICK      = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pixel_index;
    logic [14:0] packed_colour;
    logic [4:0]  red;
    logic [4:0]  green;
    logic [4:0]  blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_frame;
    logic       busy_res;
    logic       refused;
  } out_item_t;

  // Status from the frame sequencer for the beat being taken this cycle.
  typedef struct packed {
    logic busy;      // frame in flight before this beat
    logic busy_nxt;  // frame in flight after this beat
    logic last;      // this tick emits the final tail byte
    logic rd_en;     // this tick reads a pixel word
    logic hi_byte;   // take the high byte of that word
  } seq_stat_t;

endpackage

`default_nettype wire

### src/lsfs_frame_seq.sv
// Frame sequencer: phase, byte counter and latched frame length.
`timescale 1ns / 1ps
`default_nettype none

module lsfs_frame_seq #(
  parameter int unsigned MaxLeds     = lsfs_pkg::MAX_LEDS_DEF,
  parameter int unsigned HeaderBytes = lsfs_pkg::HEADER_BYTES_DEF,
  localparam int unsigned LenW  = $clog2(MaxLeds + 1),
  localparam int unsigned AddrW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 tick_i,
  input  wire logic [LenW-1:0]      len_i,
  output lsfs_pkg::seq_stat_t       stat_o,
  output logic      [AddrW-1:0]     rd_addr_o
);

  import lsfs_pkg::*;

  localparam int unsigned CntW = $clog2(2 * MaxLeds + HeaderBytes + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_TAIL
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [CntW-1:0]   cnt_inc;
  logic              last;

  assign cnt_inc = cnt_q + CntW'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    last    = 1'b0;
    if (start_i) begin
      phase_d = PH_HEADER;
      cnt_d   = '0;
      len_d   = len_i;
    end else if (tick_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(HeaderBytes)) begin
            phase_d = PH_DATA;
            cnt_d   = '0;
          end
        end
        PH_DATA: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'({len_q, 1'b0})) begin
            phase_d = PH_TAIL;
            cnt_d   = '0;
          end
        end
        PH_TAIL: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(len_q)) begin
            last    = 1'b1;
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
    end
  end

  assign stat_o.busy     = (phase_q != PH_IDLE);
  assign stat_o.busy_nxt = (phase_d != PH_IDLE);
  assign stat_o.last     = last;
  assign stat_o.rd_en    = tick_i && (phase_q == PH_DATA);
  assign stat_o.hi_byte  = ~cnt_q[0];
  assign rd_addr_o       = AddrW'(cnt_q >> 1);

endmodule

`default_nettype wire

### src/led_strip_frame_serializer.sv
// Top level: pixel word buffer, request handling, result stage and register port.
// Flow: the buffer read and the pending stage load at the accepting edge; the
// result register loads from the pending stage once it is free, then drives out.
// Throughput: one request beat per cycle; a stalled result register holds input.
// Reset: control state clears at once; the pixel buffer is then swept to black,
// one word per cycle over all MaxLeds words, with the input stalled until done.
// Register num_leds resets to 256 and is writable at any time.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_frame_serializer #(
  parameter int unsigned MaxLeds     = lsfs_pkg::MAX_LEDS_DEF,
  parameter int unsigned HeaderBytes = lsfs_pkg::HEADER_BYTES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lsfs_pkg::in_item_t in_data_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lsfs_pkg::out_item_t     out_data_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import lsfs_pkg::*;

  localparam int unsigned LenW  = $clog2(MaxLeds + 1);
  localparam int unsigned AddrW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam logic        REG_NUM_LEDS = 1'b0;

  // ---------------------------------------------------------------
  // Register port: one register, num_leds, at byte address 0.
  // ---------------------------------------------------------------
  logic [NUM_LEDS_W-1:0] num_leds_q;
  logic                  reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_leds_q <= NUM_LEDS_W'(NUM_LEDS_RESET);
    end else if (reg_wr && (paddr[2] == REG_NUM_LEDS)) begin
      num_leds_q <= pwdata[NUM_LEDS_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_LEDS: prdata = 32'(num_leds_q);
      default:      prdata = '0;
    endcase
  end

  // Effective LED count: clamp num_leds to 1..MaxLeds.
  logic [LenW-1:0] eff_len;

  always_comb begin
    if (num_leds_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(num_leds_q) > 32'(MaxLeds)) begin
      eff_len = LenW'(MaxLeds);
    end else begin
      eff_len = LenW'(num_leds_q);
    end
  end

  // ---------------------------------------------------------------
  // Handshake. The pending stage holds a request whose buffer read is in
  // flight; it moves into the result register whenever that is free.
  // ---------------------------------------------------------------
  logic clr_q;
  logic pend_q;
  logic out_valid_q;
  logic adv;
  logic acc;

  assign adv        = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_q || (pend_q && !adv);
  assign acc        = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------
  req_e                req;
  seq_stat_t           seq_stat;
  logic [AddrW-1:0]    rd_addr;
  logic                is_wr;
  logic                wr_ok;
  logic                start_ok;
  logic                tick;
  logic [COLOUR_W-1:0] wr_colour;

  assign req      = req_e'(in_data_i.req_type);
  assign is_wr    = (req == REQ_WR_PACKED) || (req == REQ_WR_RGB);
  // Refuse writes while a frame is out, or at an index past the strip.
  assign wr_ok    = acc && is_wr && !seq_stat.busy &&
                    (32'(in_data_i.pixel_index) < 32'(eff_len));
  assign start_ok = acc && (req == REQ_START) && !seq_stat.busy;
  assign tick     = acc && (req == REQ_TICK);

  // rgb writes pack green, blue, red from high to low
  assign wr_colour = (req == REQ_WR_RGB) ?
                     {in_data_i.green, in_data_i.blue, in_data_i.red} :
                     in_data_i.packed_colour;

  lsfs_frame_seq #(
    .MaxLeds     (MaxLeds),
    .HeaderBytes (HeaderBytes)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_ok),
    .tick_i    (tick),
    .len_i     (eff_len),
    .stat_o    (seq_stat),
    .rd_addr_o (rd_addr)
  );

  // ---------------------------------------------------------------
  // Pixel buffer. Bit 15 of every word is always set, so only the
  // 15 colour bits are stored. One write and one read port; a request
  // beat is either a write or a read, never both, so no forwarding.
  // ---------------------------------------------------------------
  logic [COLOUR_W-1:0] mem_q [MaxLeds];
  logic [COLOUR_W-1:0] rdata_q;
  logic [AddrW-1:0]    clr_addr_q;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [COLOUR_W-1:0] mem_wdata;

  assign mem_we    = clr_q || wr_ok;
  assign mem_waddr = clr_q ? clr_addr_q : AddrW'(in_data_i.pixel_index);
  assign mem_wdata = clr_q ? '0 : wr_colour;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (seq_stat.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sweep the buffer to black after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(MaxLeds - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Pending stage and result register
  // ---------------------------------------------------------------
  out_item_t pend_item_q;
  logic      pend_rd_q;
  logic      pend_hi_q;
  out_item_t out_data_q;
  out_item_t res_item;
  logic [7:0] rd_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        pend_q <= 1'b1;
      end else if (adv) begin
        pend_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold the result fields until the read data lands.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_item_q.out_byte      <= '0;
      pend_item_q.byte_valid    <= tick;
      pend_item_q.last_of_frame <= tick && seq_stat.last;
      pend_item_q.busy_res      <= seq_stat.busy_nxt;
      pend_item_q.refused       <= (is_wr && !wr_ok) ||
                                   ((req == REQ_START) && !start_ok);
      pend_rd_q                 <= seq_stat.rd_en;
      pend_hi_q                 <= seq_stat.hi_byte;
    end
    if (adv) begin
      out_data_q <= res_item;
    end
  end

  // High byte carries the fixed top bit of the LED word.
  always_comb begin
    if (!pend_rd_q) begin
      rd_byte = '0;
    end else if (pend_hi_q) begin
      rd_byte = {1'b1, rdata_q[COLOUR_W-1:8]};
    end else begin
      rd_byte = rdata_q[7:0];
    end
  end

  // Merge the read byte into the held result fields.
  always_comb begin
    res_item          = pend_item_q;
    res_item.out_byte = rd_byte;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> in_stall_o)
    else $error("request accepted during buffer clear");

  a_accept_fills_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> pend_q)
    else $error("accepted beat did not reach the pending stage");

  a_last_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_frame |->
      out_data_o.byte_valid && !out_data_o.busy_res)
    else $error("last byte of frame with frame still busy");

  a_byte_only_on_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_byte != '0) |->
      out_data_o.byte_valid && !out_data_o.refused)
    else $error("nonzero byte on a non-tick result");

  a_no_write_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ok |-> !seq_stat.busy && !clr_q)
    else $error("buffer written during a frame");

endmodule

`default_nettype wire
